### src/aes_pkg.sv
// Package: AES tables, widths and helper functions.
`default_nettype none
package aes_pkg;
   localparam int unsigned KeyWordsMax = 60;
   localparam int unsigned KwAddrW     = 6;
   localparam int unsigned CsrIdxW     = 3;
   localparam int unsigned CsrDataW    = 64;

   localparam logic [CsrIdxW-1:0] CSR_MODE  = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_KEY0  = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_KEY1  = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_KEY2  = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_KEY3  = 3'd4;

   localparam logic [1:0] MODE_128 = 2'd0;
   localparam logic [1:0] MODE_192 = 2'd1;

   typedef logic [127:0] block_type;

   typedef struct packed {
      logic       cmd;
      logic [63:0] block_high;
      logic [63:0] block_low;
   } req_type;

   typedef struct packed {
      logic [63:0] result_high;
      logic [63:0] result_low;
   } rsp_type;

   function automatic logic [7:0] xt(input logic [7:0] a);
      xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
      logic [7:0] p, r;
      p = a; r = 8'h00;
      for (int i = 0; i < 4; i++) begin
         if (b[i]) r = r ^ p;
         p = xt(p);
      end
      gmul = r;
   endfunction

   function automatic logic [7:0] mulf(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p, r;
      p = a; r = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) r = r ^ p;
         p = xt(p);
      end
      mulf = r;
   endfunction

   function automatic logic [7:0] inv8(input logic [7:0] a);
      // a^254 = product of a^(2^k), k=1..7
      logic [7:0] r, b;
      r = 8'h01; b = a;
      for (int k = 1; k < 8; k++) begin
         b = mulf(b, b);
         r = mulf(r, b);
      end
      inv8 = r;
   endfunction

   function automatic logic [7:0] sbox_calc(input logic [7:0] a);
      logic [7:0] q;
      q = inv8(a);
      sbox_calc = q ^ {q[6:0], q[7]} ^ {q[5:0], q[7:6]} ^ {q[4:0], q[7:5]}
                  ^ {q[3:0], q[7:4]} ^ 8'h63;
   endfunction

   typedef logic [7:0] box_type [256];

   function automatic box_type mk_fwd();
      box_type b;
      for (int i = 0; i < 256; i++) b[i] = sbox_calc(8'(i));
      mk_fwd = b;
   endfunction

   function automatic box_type mk_inv();
      box_type b;
      for (int i = 0; i < 256; i++) b[sbox_calc(8'(i))] = 8'(i);
      mk_inv = b;
   endfunction

   localparam box_type FWD_BOX = mk_fwd();
   localparam box_type INV_BOX = mk_inv();

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      sub_word = {FWD_BOX[w[31:24]], FWD_BOX[w[23:16]], FWD_BOX[w[15:8]], FWD_BOX[w[7:0]]};
   endfunction
endpackage
`default_nettype wire

### src/aes_stream_if.sv
// Interface: valid/ready channel carrying a payload.
`default_nettype none
interface aes_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### src/aes_block_cipher.sv
// Top level: AES-128/192/256 block cipher with a round key memory.
// Key expansion (one word a cycle plus entry and exit) runs after a key change;
// each request then passes the initial key addition and Nr rounds to its result.
// One request at a time: a new one is taken only once the result has been
// taken and the block is idle again; the round unit runs one round a cycle.
// Reset: synchronous, clears control; round keys are undefined until expanded.
`default_nettype none
module aes_block_cipher (
   input  wire logic                          clock,
   input  wire logic                          reset,
   aes_stream_if.sink                         req,
   aes_stream_if.source                       rsp,
   input  wire logic                          csr_we,
   input  wire logic [aes_pkg::CsrIdxW-1:0]   csr_idx,
   input  wire logic [aes_pkg::CsrDataW-1:0]  csr_wdata
);
   import aes_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_KEXP = 2'd1;
   localparam logic [1:0] ST_RUN  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0] mode_ff;
   logic [255:0] key_ff;
   logic expanded_ff;
   logic [1:0] st_ff, st_in;
   logic cmd_ff;
   block_type state_ff, state_in;
   logic [3:0] rnd_ff, rnd_in;  // round of the key being read
   logic first_ff, first_in;    // first key not yet applied
   logic [3:0] nr;

   // round key memory, four words per row, one row per round
   logic [127:0] rk_mem [KeyWordsMax/4];
   logic [127:0] rk_rd_ff;
   logic kx_busy, kx_we, kx_start;
   logic [KwAddrW-1:0] kx_addr;
   logic [31:0] kx_data;
   block_type round_out;
   logic last_rnd;

   assign nr = (mode_ff == MODE_128) ? 4'd10 : (mode_ff == MODE_192) ? 4'd12 : 4'd14;

   aes_key_exp u_kexp (
      .clock(clock), .reset(reset), .start(kx_start), .mode(mode_ff), .key(key_ff),
      .busy(kx_busy), .wr_en(kx_we), .wr_addr(kx_addr), .wr_data(kx_data));

   // write one word into its row; read the row selected by the next round index
   always_ff @(posedge clock) begin
      if (kx_we) rk_mem[kx_addr[KwAddrW-1:2]][127 - 32*kx_addr[1:0] -: 32] <= kx_data;
      rk_rd_ff <= rk_mem[rnd_in];
   end

   aes_round u_round (.inv(cmd_ff), .last(last_rnd), .din(state_ff), .rk(rk_rd_ff),
                      .dout(round_out));

   // last round: encrypt reads key nr, decrypt key 0
   assign last_rnd = cmd_ff ? (rnd_ff == 4'd0) : (rnd_ff == nr);
   assign kx_start = (st_ff == ST_IDLE) && req.valid && !expanded_ff;
   assign req.ready = (st_ff == ST_IDLE) && expanded_ff;
   assign rsp.valid = (st_ff == ST_OUT);
   assign rsp.data  = {state_ff[127:64], state_ff[63:0]};

   always_comb begin
      st_in = st_ff; state_in = state_ff; rnd_in = rnd_ff; first_in = first_ff;
      case (st_ff)
         ST_IDLE: begin
            if (kx_start) st_in = ST_KEXP;
            else if (req.valid && req.ready) begin
               st_in = ST_RUN;
               state_in = {req.data.block_high, req.data.block_low};
               rnd_in = req.data.cmd ? nr : 4'd0;
               first_in = 1'b1;
            end
         end
         ST_KEXP: if (!kx_busy) st_in = ST_IDLE;
         ST_RUN: begin
            if (first_ff) begin
               state_in = state_ff ^ rk_rd_ff;
               first_in = 1'b0;
               rnd_in = cmd_ff ? rnd_ff - 4'd1 : rnd_ff + 4'd1;
            end else begin
               state_in = round_out;
               if (last_rnd) st_in = ST_OUT;
               else rnd_in = cmd_ff ? rnd_ff - 4'd1 : rnd_ff + 4'd1;
            end
         end
         ST_OUT: if (rsp.ready) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; expanded_ff <= 1'b0; mode_ff <= MODE_128;
         key_ff <= '0; rnd_ff <= '0; first_ff <= 1'b0; cmd_ff <= 1'b0;
      end else begin
         st_ff <= st_in; rnd_ff <= rnd_in; first_ff <= first_in;
         if (st_ff == ST_IDLE && req.valid && req.ready) cmd_ff <= req.data.cmd;
         if (st_ff == ST_KEXP && !kx_busy) expanded_ff <= 1'b1;
         if (csr_we) begin
            case (csr_idx)
               CSR_MODE: begin mode_ff <= csr_wdata[1:0]; expanded_ff <= 1'b0; end
               CSR_KEY0: begin key_ff[255:192] <= csr_wdata; expanded_ff <= 1'b0; end
               CSR_KEY1: begin key_ff[191:128] <= csr_wdata; expanded_ff <= 1'b0; end
               CSR_KEY2: begin key_ff[127:64]  <= csr_wdata; expanded_ff <= 1'b0; end
               CSR_KEY3: begin key_ff[63:0]    <= csr_wdata; expanded_ff <= 1'b0; end
               default: ;
            endcase
         end
      end
      state_ff <= state_in;
   end
endmodule
`default_nettype wire

### src/aes_key_exp.sv
// Key expansion sequencer: writes one round key word per cycle into the key store.
`default_nettype none
module aes_key_exp (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [1:0]                  mode,
   input  wire logic [255:0]                key,
   output logic                             busy,
   output logic                             wr_en,
   output logic [aes_pkg::KwAddrW-1:0]      wr_addr,
   output logic [31:0]                      wr_data
);
   import aes_pkg::*;
   // window of the last eight words
   logic [31:0] win_ff [8];
   logic [31:0] win_in [8];
   logic [KwAddrW-1:0] idx_ff, idx_in;
   logic [3:0] pos_ff, pos_in;   // i mod nk
   logic [7:0] rcon_ff, rcon_in;
   logic busy_ff, busy_in;
   logic [3:0] nk;
   logic [KwAddrW-1:0] total;
   logic [31:0] t, w;

   always_comb begin
      nk    = (mode == MODE_128) ? 4'd4 : (mode == MODE_192) ? 4'd6 : 4'd8;
      total = (mode == MODE_128) ? 6'd44 : (mode == MODE_192) ? 6'd52 : 6'd60;
      t = win_ff[0];
      if (idx_ff < KwAddrW'(nk)) begin
         w = key[255 - 32*idx_ff[2:0] -: 32];
      end else begin
         if (pos_ff == 4'd0) t = sub_word({t[23:0], t[31:24]}) ^ {rcon_ff, 24'h0};
         else if (nk == 4'd8 && pos_ff == 4'd4) t = sub_word(t);
         w = win_ff[3'(nk - 4'd1)] ^ t;
      end
      busy_in = busy_ff;
      idx_in  = idx_ff;
      pos_in  = pos_ff;
      rcon_in = rcon_ff;
      for (int k = 0; k < 8; k++) win_in[k] = win_ff[k];
      if (start) begin
         busy_in = 1'b1; idx_in = '0; pos_in = '0; rcon_in = 8'h01;
      end else if (busy_ff) begin
         for (int k = 1; k < 8; k++) win_in[k] = win_ff[k-1];
         win_in[0] = w;
         if (idx_ff >= KwAddrW'(nk) && pos_ff == 4'd0) rcon_in = xt(rcon_ff);
         pos_in = (pos_ff == nk - 4'd1) ? 4'd0 : pos_ff + 4'd1;
         idx_in = idx_ff + 1'b1;
         if (idx_ff == total - 1'b1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
         pos_ff  <= '0;
         rcon_ff <= 8'h01;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
         pos_ff  <= pos_in;
         rcon_ff <= rcon_in;
      end
      for (int k = 0; k < 8; k++) win_ff[k] <= win_in[k];
   end

   assign busy    = busy_ff;
   assign wr_en   = busy_ff && !start;
   assign wr_addr = idx_ff;
   assign wr_data = w;
endmodule
`default_nettype wire

### src/aes_round.sv
// One AES round, forward or inverse, on a 128-bit state.
`default_nettype none
module aes_round (
   input  wire logic                 inv,
   input  wire logic                 last,
   input  wire aes_pkg::block_type   din,
   input  wire aes_pkg::block_type   rk,
   output aes_pkg::block_type        dout
);
   import aes_pkg::*;
   logic [7:0] s [16];
   logic [7:0] t [16];
   logic [7:0] m [16];
   logic [7:0] o [16];
   always_comb begin
      for (int i = 0; i < 16; i++) s[i] = din[127 - 8*i -: 8];
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++) begin
            if (inv) t[4*((c+r)%4)+r] = INV_BOX[s[4*c+r]];
            else     t[4*c+r] = FWD_BOX[s[4*((c+r)%4)+r]];
         end
      // forward: mix then key; inverse: key then mix
      for (int i = 0; i < 16; i++) m[i] = inv ? (t[i] ^ rk[127 - 8*i -: 8]) : t[i];
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++) begin
            if (last) o[4*c+r] = m[4*c+r];
            else if (inv)
               o[4*c+r] = gmul(m[4*c+r], 4'd14) ^ gmul(m[4*c+(r+1)%4], 4'd11)
                        ^ gmul(m[4*c+(r+2)%4], 4'd13) ^ gmul(m[4*c+(r+3)%4], 4'd9);
            else
               o[4*c+r] = gmul(m[4*c+r], 4'd2) ^ gmul(m[4*c+(r+1)%4], 4'd3)
                        ^ m[4*c+(r+2)%4] ^ m[4*c+(r+3)%4];
         end
      for (int i = 0; i < 16; i++)
         dout[127 - 8*i -: 8] = inv ? o[i] : (o[i] ^ rk[127 - 8*i -: 8]);
   end
endmodule
`default_nettype wire

### src/aes_block_cipher_chk.sv
// Checker: port-level properties of the cipher, bound to the top level.
`default_nettype none
module aes_block_cipher_chk (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("rsp dropped");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken with response pending");
   a_no_fast: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid) else $error("response too early");
endmodule
bind aes_block_cipher aes_block_cipher_chk u_chk (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready));
`default_nettype wire
